// File: rtl/lpcq_pkg.sv
// ----------------------------------------------------------------------------
// lpcq_pkg: shared types and constants of the lidar point curvature qualifier
// Point, result, configuration and per-evaluation control types, register
// indexes and reset values.
// ----------------------------------------------------------------------------
package lpcq_pkg;

    localparam int COORD_W    = 24;
    localparam int THR_W      = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int JUMP_STEPS = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_RANGE_SQ  = 3'd0,
        REG_MIN_RANGE_SQ  = 3'd1,
        REG_Z_LOW         = 3'd2,
        REG_Z_HIGH        = 3'd3,
        REG_JUMP_LIMIT_SQ = 3'd4,
        REG_EDGE_THRESH   = 3'd5,
        REG_FLAT_THRESH   = 3'd6
    } cfg_idx_t;

    localparam logic [THR_W-1:0]          RST_MAX_RANGE_SQ  = 48'd822083584;
    localparam logic [THR_W-1:0]          RST_MIN_RANGE_SQ  = 48'd1;
    localparam logic signed [COORD_W-1:0] RST_Z_LOW         = -24'sd123;
    localparam logic signed [COORD_W-1:0] RST_Z_HIGH        = 24'sd1229;
    localparam logic [THR_W-1:0]          RST_JUMP_LIMIT_SQ = 48'd838861;
    localparam logic [THR_W-1:0]          RST_EDGE_THRESH   = 48'd8388608;
    localparam logic [THR_W-1:0]          RST_FLAT_THRESH   = 48'd1677722;

    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic                      frame_end;
    } pt_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic signed [COORD_W-1:0] out_z;
        logic [THR_W-1:0]          curvature;
        logic                      range_reject;
        logic                      usable;
        logic                      edge_candidate;
        logic                      flat_candidate;
        logic                      last_of_frame;
    } res_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } point_t;

    typedef struct packed {
        logic emit;
        logic curv_ok;
        logic jump_ok;
        logic last;
    } meta_t;

    typedef struct packed {
        logic [THR_W-1:0]          max_range_sq;
        logic [THR_W-1:0]          min_range_sq;
        logic signed [COORD_W-1:0] z_low;
        logic signed [COORD_W-1:0] z_high;
        logic [THR_W-1:0]          jump_limit_sq;
        logic [THR_W-1:0]          edge_threshold;
        logic [THR_W-1:0]          flat_threshold;
    } cfg_t;

endpackage

// File: rtl/lpcq_cell.sv
// ----------------------------------------------------------------------------
// lpcq_cell: one point of the scan window
// Holds a point and takes its neighbor's point on every window shift.
// ----------------------------------------------------------------------------
module lpcq_cell (
    input  logic            clk,
    input  logic            shift,
    input  lpcq_pkg::point_t d,
    output lpcq_pkg::point_t q
);
    import lpcq_pkg::*;

    point_t q_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            q_reg <= d;
        end
    end

    assign q = q_reg;

endmodule

// File: rtl/lpcq_eval.sv
// ----------------------------------------------------------------------------
// lpcq_eval: curvature and qualification pipeline
// Reads the window taps around the center cell and produces one result per
// evaluation through sums, squares, compares and an output register.
// ----------------------------------------------------------------------------
module lpcq_eval #(
    parameter int CURV_HALF = 5,
    parameter int WIN_HALF  = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lpcq_pkg::point_t [2*WIN_HALF:0] win,
    input  lpcq_pkg::meta_t               meta,
    output logic                          load_ready,
    input  lpcq_pkg::cfg_t                cfg,
    output logic                          res_valid,
    input  logic                          res_ready,
    output lpcq_pkg::res_t                res
);
    import lpcq_pkg::*;

    localparam int LW    = COORD_W + $clog2(2 * CURV_HALF) + 2;
    localparam int SQW   = 2 * LW - 1;
    localparam int CSW   = SQW + 2;
    localparam int DW    = COORD_W + 1;
    localparam int DSQW  = 2 * DW - 1;
    localparam int DSUMW = DSQW + 2;
    localparam int RSQW  = 2 * COORD_W - 1;
    localparam int NJ    = 2 * JUMP_STEPS;

    function automatic logic signed [COORD_W-1:0] axis_of(point_t p, int a);
        unique case (a)
            0:       return p.x;
            1:       return p.y;
            default: return p.z;
        endcase
    endfunction

    // stage 1: laplacian sums and neighbor differences
    logic                 s1_v_reg;
    meta_t                s1_meta_reg;
    point_t               s1_c_reg;
    logic signed [LW-1:0] s1_lap_reg [3];
    logic signed [DW-1:0] s1_dif_reg [NJ][3];

    // stage 2: squares
    logic                 s2_v_reg;
    meta_t                s2_meta_reg;
    point_t               s2_c_reg;
    logic [SQW-1:0]       s2_lap_sq_reg [3];
    logic [RSQW-1:0]      s2_rng_sq_reg [3];
    logic [DSQW-1:0]      s2_dif_sq_reg [NJ][3];

    // stage 3: sums and compares
    logic                 s3_v_reg;
    meta_t                s3_meta_reg;
    point_t               s3_c_reg;
    logic [THR_W-1:0]     s3_curv_reg;
    logic                 s3_reject_reg;
    logic                 s3_zok_reg;
    logic                 s3_jbad_reg;

    logic                 res_valid_reg;
    res_t                 res_reg;

    logic take1, take2, take3, take4;

    logic signed [LW-1:0] lap_d [3];
    logic signed [DW-1:0] dif_d [NJ][3];
    logic [SQW-1:0]       lap_sq_d [3];
    logic [RSQW-1:0]      rng_sq_d [3];
    logic [DSQW-1:0]      dif_sq_d [NJ][3];
    logic [THR_W-1:0]     curv_d;
    logic                 reject_d;
    logic                 zok_d;
    logic                 jbad_d;
    logic                 usable_d;

    assign take4      = !res_valid_reg || res_ready;
    assign take3      = !s3_v_reg || take4;
    assign take2      = !s2_v_reg || take3;
    assign take1      = !s1_v_reg || take2;
    assign load_ready = take1;

    always_comb
    begin
        point_t               c;
        logic signed [LW-1:0] acc;
        c = win[WIN_HALF];
        for (int a = 0; a < 3; a++)
        begin
            acc = '0;
            for (int j = 1; j <= CURV_HALF; j++)
            begin
                acc = acc + LW'(axis_of(win[WIN_HALF-j], a))
                          + LW'(axis_of(win[WIN_HALF+j], a));
            end
            lap_d[a] = acc - LW'(2 * CURV_HALF) * LW'(axis_of(c, a));
            for (int j = 0; j < JUMP_STEPS; j++)
            begin
                dif_d[j][a] = DW'(axis_of(c, a)) - DW'(axis_of(win[WIN_HALF-j-1], a));
                dif_d[JUMP_STEPS+j][a] = DW'(axis_of(c, a))
                                       - DW'(axis_of(win[WIN_HALF+j+1], a));
            end
        end
    end

    always_comb
    begin
        logic signed [2*LW-1:0]      lp;
        logic signed [2*COORD_W-1:0] rp;
        logic signed [2*DW-1:0]      dp;
        for (int a = 0; a < 3; a++)
        begin
            lp          = s1_lap_reg[a] * s1_lap_reg[a];
            lap_sq_d[a] = lp[SQW-1:0];
            rp          = axis_of(s1_c_reg, a) * axis_of(s1_c_reg, a);
            rng_sq_d[a] = rp[RSQW-1:0];
            for (int j = 0; j < NJ; j++)
            begin
                dp             = s1_dif_reg[j][a] * s1_dif_reg[j][a];
                dif_sq_d[j][a] = dp[DSQW-1:0];
            end
        end
    end

    always_comb
    begin
        logic [CSW-1:0]   csum;
        logic [THR_W-1:0] r2;
        logic [DSUMW-1:0] dsum;
        csum = CSW'(s2_lap_sq_reg[0]) + CSW'(s2_lap_sq_reg[1]) + CSW'(s2_lap_sq_reg[2]);
        r2   = THR_W'(s2_rng_sq_reg[0]) + THR_W'(s2_rng_sq_reg[1])
             + THR_W'(s2_rng_sq_reg[2]);
        jbad_d = 1'b0;
        for (int j = 0; j < NJ; j++)
        begin
            dsum = DSUMW'(s2_dif_sq_reg[j][0]) + DSUMW'(s2_dif_sq_reg[j][1])
                 + DSUMW'(s2_dif_sq_reg[j][2]);
            if (dsum > DSUMW'(cfg.jump_limit_sq))
            begin
                jbad_d = 1'b1;
            end
        end
        if (!s2_meta_reg.curv_ok)
        begin
            curv_d = '0;
        end
        else if (|csum[CSW-1:THR_W])
        begin
            curv_d = '1;
        end
        else
        begin
            curv_d = csum[THR_W-1:0];
        end
        reject_d = s2_meta_reg.curv_ok && ((r2 > cfg.max_range_sq) || (r2 < cfg.min_range_sq));
        zok_d    = s2_meta_reg.curv_ok && (s2_c_reg.z >= cfg.z_low)
                && (s2_c_reg.z <= cfg.z_high);
    end

    assign usable_d = s3_zok_reg && !s3_reject_reg && !s3_jbad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            s3_v_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (take1)
            begin
                s1_v_reg <= meta.emit;
            end
            if (take2)
            begin
                s2_v_reg <= s1_v_reg;
            end
            if (take3)
            begin
                s3_v_reg <= s2_v_reg;
            end
            if (take4)
            begin
                res_valid_reg <= s3_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take1)
        begin
            s1_meta_reg <= meta;
            s1_c_reg    <= win[WIN_HALF];
            s1_lap_reg  <= lap_d;
            s1_dif_reg  <= dif_d;
        end
        if (take2)
        begin
            s2_meta_reg   <= s1_meta_reg;
            s2_c_reg      <= s1_c_reg;
            s2_lap_sq_reg <= lap_sq_d;
            s2_rng_sq_reg <= rng_sq_d;
            s2_dif_sq_reg <= dif_sq_d;
        end
        if (take3)
        begin
            s3_meta_reg   <= s2_meta_reg;
            s3_c_reg      <= s2_c_reg;
            s3_curv_reg   <= curv_d;
            s3_reject_reg <= reject_d;
            s3_zok_reg    <= zok_d;
            s3_jbad_reg   <= s2_meta_reg.jump_ok && jbad_d;
        end
        if (take4)
        begin
            res_reg.out_x          <= s3_c_reg.x;
            res_reg.out_y          <= s3_c_reg.y;
            res_reg.out_z          <= s3_c_reg.z;
            res_reg.curvature      <= s3_curv_reg;
            res_reg.range_reject   <= s3_reject_reg;
            res_reg.usable         <= usable_d;
            res_reg.edge_candidate <= usable_d && (s3_curv_reg > cfg.edge_threshold);
            res_reg.flat_candidate <= usable_d && (s3_curv_reg < cfg.flat_threshold);
            res_reg.last_of_frame  <= s3_meta_reg.last;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// File: rtl/lidar_point_curvature_qualifier.sv
// ----------------------------------------------------------------------------
// lidar_point_curvature_qualifier: scan-line curvature and point qualification
// Shifts each point into a chain of window cells and qualifies the center
// point: curvature, range and z checks, neighbor jump check, edge/flat flags.
//
//   channel  | signals                         | role
//   ---------+---------------------------------+-------------------------------
//   point    | pt_valid, pt_ready, pt          | one scan point per transaction
//   result   | res_valid, res_ready, res       | one qualified point
//   config   | cfg_we, cfg_idx, cfg_data       | register write, no wait
//
// One point per cycle while pt_ready is high. A point with frame_end set holds
// pt_ready low while the chain shifts its WIN_HALF pending points through
// the center cell. A result passes the stage 1, 2 and 3 registers and then
// the output register once its point sits in the center cell.
// Reset clears the control state and loads the register defaults.
// res_ready low stalls the pipeline stage by stage, then the chain and input.
// ----------------------------------------------------------------------------
module lidar_point_curvature_qualifier #(
    parameter int CURV_HALF   = 5,
    parameter int JUMP_MARGIN = 10
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                pt_valid,
    output logic                                pt_ready,
    input  lpcq_pkg::pt_t                       pt,
    output logic                                res_valid,
    input  logic                                res_ready,
    output lpcq_pkg::res_t                      res,
    input  logic                                cfg_we,
    input  logic [lpcq_pkg::CFG_IDX_W-1:0]      cfg_idx,
    input  logic [lpcq_pkg::THR_W-1:0]          cfg_data
);
    import lpcq_pkg::*;

    localparam int WIN_HALF = (CURV_HALF > JUMP_MARGIN) ? CURV_HALF : JUMP_MARGIN;
    localparam int WIN_LEN  = 2 * WIN_HALF + 1;
    localparam int CNT_MAX  = 2 * WIN_HALF;
    localparam int CW       = $clog2(CNT_MAX + 1);
    localparam int SW       = $clog2(WIN_HALF + 1);

    function automatic meta_t meta_of(int o, int p, logic last);
        meta_t m;
        m.emit    = (o <= p);
        m.curv_ok = (o >= CURV_HALF) && (p >= o + CURV_HALF);
        m.jump_ok = (o >= JUMP_MARGIN) && (p >= o + JUMP_MARGIN);
        m.last    = last;
        return m;
    endfunction

    cfg_t            cfg_reg;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [CW-1:0]   pf_reg, pf_next;
    logic [SW-1:0]   step_reg, step_next;
    logic            flush_reg, flush_next;
    meta_t           ev_reg, ev_next;

    point_t [WIN_LEN-1:0] win;
    point_t          head;
    logic            accept;
    logic            shift;
    logic            win_adv;
    logic            load_ready;

    assign win_adv  = !ev_reg.emit || load_ready;
    assign pt_ready = win_adv && !flush_reg;
    assign accept   = pt_valid && pt_ready;
    assign shift    = accept || (flush_reg && win_adv);

    always_comb
    begin
        head = '0;
        if (!flush_reg)
        begin
            head.x = pt.pos_x;
            head.y = pt.pos_y;
            head.z = pt.pos_z;
        end
    end

    for (genvar i = 0; i < WIN_LEN; i++)
    begin : g_chain
        if (i == 0)
        begin : g_head
            lpcq_cell u_cell (
                .clk   (clk),
                .shift (shift),
                .d     (head),
                .q     (win[i])
            );
        end
        else
        begin : g_body
            lpcq_cell u_cell (
                .clk   (clk),
                .shift (shift),
                .d     (win[i-1]),
                .q     (win[i])
            );
        end
    end

    always_comb
    begin
        cnt_next   = cnt_reg;
        pf_next    = pf_reg;
        step_next  = step_reg;
        flush_next = flush_reg;
        ev_next    = ev_reg;
        if (accept)
        begin
            ev_next = meta_of(WIN_HALF, int'(cnt_reg), 1'b0);
            if (pt.frame_end)
            begin
                cnt_next   = '0;
                pf_next    = cnt_reg;
                step_next  = SW'(1);
                flush_next = 1'b1;
            end
            else if (cnt_reg != CW'(CNT_MAX))
            begin
                cnt_next = cnt_reg + CW'(1);
            end
        end
        else if (flush_reg && win_adv)
        begin
            ev_next = meta_of(WIN_HALF - int'(step_reg), int'(pf_reg),
                              step_reg == SW'(WIN_HALF));
            if (step_reg == SW'(WIN_HALF))
            begin
                flush_next = 1'b0;
            end
            else
            begin
                step_next = step_reg + SW'(1);
            end
        end
        else if (win_adv)
        begin
            ev_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            pf_reg    <= '0;
            step_reg  <= '0;
            flush_reg <= 1'b0;
            ev_reg    <= '0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            pf_reg    <= pf_next;
            step_reg  <= step_next;
            flush_reg <= flush_next;
            ev_reg    <= ev_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_range_sq   <= RST_MAX_RANGE_SQ;
            cfg_reg.min_range_sq   <= RST_MIN_RANGE_SQ;
            cfg_reg.z_low          <= RST_Z_LOW;
            cfg_reg.z_high         <= RST_Z_HIGH;
            cfg_reg.jump_limit_sq  <= RST_JUMP_LIMIT_SQ;
            cfg_reg.edge_threshold <= RST_EDGE_THRESH;
            cfg_reg.flat_threshold <= RST_FLAT_THRESH;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_idx))
                REG_MAX_RANGE_SQ:  cfg_reg.max_range_sq   <= cfg_data;
                REG_MIN_RANGE_SQ:  cfg_reg.min_range_sq   <= cfg_data;
                REG_Z_LOW:         cfg_reg.z_low          <= cfg_data[COORD_W-1:0];
                REG_Z_HIGH:        cfg_reg.z_high         <= cfg_data[COORD_W-1:0];
                REG_JUMP_LIMIT_SQ: cfg_reg.jump_limit_sq  <= cfg_data;
                REG_EDGE_THRESH:   cfg_reg.edge_threshold <= cfg_data;
                REG_FLAT_THRESH:   cfg_reg.flat_threshold <= cfg_data;
                default:           ;
            endcase
        end
    end

    lpcq_eval #(
        .CURV_HALF (CURV_HALF),
        .WIN_HALF  (WIN_HALF)
    ) u_eval (
        .clk        (clk),
        .rst_n      (rst_n),
        .win        (win),
        .meta       (ev_reg),
        .load_ready (load_ready),
        .cfg        (cfg_reg),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    a_frame_end_flush : assert property (@(posedge clk) disable iff (!rst_n)
        pt_valid && pt_ready && pt.frame_end |=> flush_reg && !pt_ready)
        else $error("frame end transaction did not start the flush");

    a_last_unqualified : assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.last_of_frame |-> !res.usable && (res.curvature == '0)
            && !res.edge_candidate && !res.flat_candidate)
        else $error("last point of frame carries a curvature or usable flag");

    a_flush_step : assert property (@(posedge clk) disable iff (!rst_n)
        flush_reg |-> (step_reg != '0) && (step_reg <= SW'(WIN_HALF)))
        else $error("flush step out of range");

    a_count_sat : assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == CW'(CNT_MAX) && pt_valid && pt_ready && !pt.frame_end
            |=> cnt_reg == CW'(CNT_MAX))
        else $error("point count left saturation");

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: scan-line curvature qualifier testbench
// Streams frames of lidar points through the block with random idle cycles on
// both sides, predicts every qualified point from a local copy of the point
// window and register set, and checks each result transaction field by field.
// ----------------------------------------------------------------------------
module tb;

    import lpcq_pkg::*;

    localparam int CURV_HALF   = 5;
    localparam int JUMP_MARGIN = 10;
    localparam int WIN_HALF    = (CURV_HALF > JUMP_MARGIN) ? CURV_HALF : JUMP_MARGIN;
    localparam int WIN_LEN     = 2 * WIN_HALF + 1;
    localparam int SETTLE_CYC  = 40;
    localparam longint CURV_MAX = 64'h0000_FFFF_FFFF_FFFF;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic             pt_valid = 1'b0;
    logic             pt_ready;
    pt_t              pt = '0;
    logic             res_valid;
    logic             res_ready = 1'b0;
    res_t             res;
    logic             cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [THR_W-1:0] cfg_data = '0;

    pt_t  scan_points[$];
    res_t qualified_q[$];
    int   mismatch_cnt = 0;
    int   tx_gap = 0;
    int   tx_calm = 0;
    int   rx_stall = 0;
    int   rx_calm = 0;
    int   rx_draw;

    point_t      scan_win[WIN_LEN];
    int unsigned seen_cnt = 0;

    logic [THR_W-1:0]          lim_max_range = RST_MAX_RANGE_SQ;
    logic [THR_W-1:0]          lim_min_range = RST_MIN_RANGE_SQ;
    logic signed [COORD_W-1:0] z_lo          = RST_Z_LOW;
    logic signed [COORD_W-1:0] z_hi          = RST_Z_HIGH;
    logic [THR_W-1:0]          lim_jump      = RST_JUMP_LIMIT_SQ;
    logic [THR_W-1:0]          thr_edge      = RST_EDGE_THRESH;
    logic [THR_W-1:0]          thr_flat      = RST_FLAT_THRESH;

    lidar_point_curvature_qualifier u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pt_valid  (pt_valid),
        .pt_ready  (pt_ready),
        .pt        (pt),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int draw_wait(inout int calm_left);
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
            calm_left = $urandom_range(8, 30);
        return $urandom_range(0, 12);
    endfunction

    function automatic longint step_sq(int a, int b);
        longint dx, dy, dz;
        dx = longint'(scan_win[a].x) - longint'(scan_win[b].x);
        dy = longint'(scan_win[a].y) - longint'(scan_win[b].y);
        dz = longint'(scan_win[a].z) - longint'(scan_win[b].z);
        return dx * dx + dy * dy + dz * dz;
    endfunction

    function automatic res_t qualify_point(int o, int unsigned p, bit last);
        res_t   r;
        longint cx, cy, cz, lx, ly, lz, curv, r2;
        bit     rej, ok;
        int     j;
        cx   = scan_win[o].x;
        cy   = scan_win[o].y;
        cz   = scan_win[o].z;
        curv = 0;
        rej  = 1'b0;
        ok   = 1'b0;
        if (o >= CURV_HALF && p >= o + CURV_HALF)
        begin
            lx = 0;
            ly = 0;
            lz = 0;
            for (j = 1; j <= CURV_HALF; j++)
            begin
                lx = lx + longint'(scan_win[o - j].x) + longint'(scan_win[o + j].x);
                ly = ly + longint'(scan_win[o - j].y) + longint'(scan_win[o + j].y);
                lz = lz + longint'(scan_win[o - j].z) + longint'(scan_win[o + j].z);
            end
            lx   = lx - 2 * CURV_HALF * cx;
            ly   = ly - 2 * CURV_HALF * cy;
            lz   = lz - 2 * CURV_HALF * cz;
            curv = lx * lx + ly * ly + lz * lz;
            if (curv > CURV_MAX)
                curv = CURV_MAX;
            r2  = cx * cx + cy * cy + cz * cz;
            rej = (r2 > longint'(lim_max_range)) || (r2 < longint'(lim_min_range));
            ok  = !rej && cz >= longint'(z_lo) && cz <= longint'(z_hi);
            if (o >= JUMP_MARGIN && p >= o + JUMP_MARGIN)
            begin
                for (j = 1; j <= JUMP_STEPS; j++)
                begin
                    if (step_sq(o - j, o) > longint'(lim_jump) ||
                        step_sq(o, o + j) > longint'(lim_jump))
                        ok = 1'b0;
                end
            end
        end
        r.out_x          = scan_win[o].x;
        r.out_y          = scan_win[o].y;
        r.out_z          = scan_win[o].z;
        r.curvature      = curv[THR_W-1:0];
        r.range_reject   = rej;
        r.usable         = ok;
        r.edge_candidate = ok && (curv > longint'(thr_edge));
        r.flat_candidate = ok && (curv < longint'(thr_flat));
        r.last_of_frame  = last;
        return r;
    endfunction

    task automatic shift_in_point(input pt_t item);
        int unsigned p;
        int          o;
        p = seen_cnt;
        for (o = WIN_LEN - 1; o > 0; o--)
            scan_win[o] = scan_win[o - 1];
        scan_win[0].x = item.pos_x;
        scan_win[0].y = item.pos_y;
        scan_win[0].z = item.pos_z;
        if (p >= WIN_HALF)
            qualified_q.insert(qualified_q.size(), qualify_point(WIN_HALF, p, 1'b0));
        if (item.frame_end)
        begin
            o = (p < WIN_HALF - 1) ? int'(p) : WIN_HALF - 1;
            while (o >= 0)
            begin
                qualified_q.insert(qualified_q.size(), qualify_point(o, p, o == 0));
                o--;
            end
            seen_cnt = 0;
        end
        else if (seen_cnt != 32'hFFFF_FFFF)
            seen_cnt++;
    endtask

    task automatic log_mismatch(input string msg);
        if (mismatch_cnt < 40)
            $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatch_cnt++;
    endtask

    task automatic cmp_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
        if (got !== want)
            log_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    task automatic check_result(input res_t got);
        res_t want;
        if (qualified_q.size() == 0)
        begin
            log_mismatch("result transaction with no point pending");
            return;
        end
        want = qualified_q.pop_front();
        cmp_field("out_x", got.out_x, want.out_x);
        cmp_field("out_y", got.out_y, want.out_y);
        cmp_field("out_z", got.out_z, want.out_z);
        cmp_field("curvature", got.curvature, want.curvature);
        cmp_field("range_reject", got.range_reject, want.range_reject);
        cmp_field("usable", got.usable, want.usable);
        cmp_field("edge_candidate", got.edge_candidate, want.edge_candidate);
        cmp_field("flat_candidate", got.flat_candidate, want.flat_candidate);
        cmp_field("last_of_frame", got.last_of_frame, want.last_of_frame);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pt_valid <= 1'b0;
            pt       <= '0;
            tx_gap   <= 0;
        end
        else
        begin
            if (pt_valid && pt_ready)
                shift_in_point(pt);
            if (!pt_valid || pt_ready)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap   <= tx_gap - 1;
                    pt_valid <= 1'b0;
                end
                else if (scan_points.size() > 0)
                begin
                    pt       <= scan_points.pop_front();
                    pt_valid <= 1'b1;
                    tx_gap   <= draw_wait(tx_calm);
                end
                else
                    pt_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ready <= 1'b0;
            rx_stall  <= 0;
        end
        else if (res_valid && res_ready)
        begin
            check_result(res);
            rx_draw = draw_wait(rx_calm);
            rx_stall  <= rx_draw;
            res_ready <= (rx_draw == 0);
        end
        else if (rx_stall > 0)
        begin
            rx_stall  <= rx_stall - 1;
            res_ready <= (rx_stall == 1);
        end
        else
            res_ready <= 1'b1;
    end

    task automatic wait_drained();
        while (scan_points.size() != 0 || pt_valid || qualified_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [THR_W-1:0] val);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_MAX_RANGE_SQ:  lim_max_range = val;
            REG_MIN_RANGE_SQ:  lim_min_range = val;
            REG_Z_LOW:         z_lo = val[COORD_W-1:0];
            REG_Z_HIGH:        z_hi = val[COORD_W-1:0];
            REG_JUMP_LIMIT_SQ: lim_jump = val;
            REG_EDGE_THRESH:   thr_edge = val;
            REG_FLAT_THRESH:   thr_flat = val;
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [THR_W-1:0] max_r, input logic [THR_W-1:0] min_r,
                             input int zl, input int zh, input logic [THR_W-1:0] jmp,
                             input logic [THR_W-1:0] edg, input logic [THR_W-1:0] flt);
        write_reg(REG_MAX_RANGE_SQ, max_r);
        write_reg(REG_MIN_RANGE_SQ, min_r);
        write_reg(REG_Z_LOW, THR_W'(zl));
        write_reg(REG_Z_HIGH, THR_W'(zh));
        write_reg(REG_JUMP_LIMIT_SQ, jmp);
        write_reg(REG_EDGE_THRESH, edg);
        write_reg(REG_FLAT_THRESH, flt);
    endtask

    task automatic push_point(input int x, input int y, input int z, input bit fe);
        pt_t item;
        item.pos_x     = x[COORD_W-1:0];
        item.pos_y     = y[COORD_W-1:0];
        item.pos_z     = z[COORD_W-1:0];
        item.frame_end = fe;
        scan_points.insert(scan_points.size(), item);
    endtask

    task automatic add_frame(input int len, input int pause_at);
        int mode, amp, k, x, y, z;
        mode = $urandom_range(0, 9);
        amp  = $urandom_range(20, 500);
        x    = int'($urandom_range(0, 40000)) - 20000;
        y    = int'($urandom_range(0, 40000)) - 20000;
        z    = int'($urandom_range(0, 1600)) - 300;
        for (k = 0; k < len; k++)
        begin
            if (pause_at > 0 && k == pause_at)
                wait_drained();
            if (mode < 2)
                push_point($urandom, $urandom, $urandom, k == len - 1);
            else
            begin
                x = x + int'($urandom_range(0, 2 * amp)) - amp;
                y = y + int'($urandom_range(0, 2 * amp)) - amp;
                z = z + int'($urandom_range(0, 120)) - 60;
                if (mode < 5 && $urandom_range(0, 7) == 0)
                    x = x + ($urandom_range(0, 1) ? 6000 : -6000);
                push_point(x, y, z, k == len - 1);
            end
        end
    endtask

    task automatic add_frames(input int n_items);
        int len;
        while (n_items > 0)
        begin
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : $urandom_range(11, 40);
            if (len > n_items)
                len = n_items;
            add_frame(len, 0);
            n_items = n_items - len;
        end
    endtask

    initial
    begin
        int k;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        push_point(8388607, 8388607, 8388607, 1'b1);
        push_point(-8388608, -8388608, -8388608, 1'b0);
        push_point(0, 0, 0, 1'b1);
        for (k = 0; k < 11; k++)
        begin
            if (k == 5)
                push_point(8388607, 8388607, 8388607, 1'b0);
            else
                push_point(-8388608, -8388608, -8388608, k == 10);
        end
        for (k = 0; k < 11; k++)
            push_point(1000, (k == 5) ? 2000 : 0, 100, k == 10);
        add_frames(30);
        wait_drained();

        write_all(48'hFFFF_FFFF_FFFF, 48'd0, -8388608, 8388607,
                  48'hFFFF_FFFF_FFFF, 48'd0, 48'hFFFF_FFFF_FFFF);
        add_frames(15);
        wait_drained();

        write_all(48'd0, 48'hFFFF_FFFF_FFFF, 8388607, -8388608,
                  48'd0, 48'hFFFF_FFFF_FFFF, 48'd0);
        add_frames(15);
        wait_drained();

        write_all(THR_W'($urandom_range(200000000, 1500000000)),
                  THR_W'($urandom_range(0, 1000000)),
                  int'($urandom_range(0, 2200)) - 2000,
                  int'($urandom_range(300, 3000)),
                  THR_W'($urandom_range(100000, 4000000)),
                  THR_W'($urandom_range(1000000, 40000000)),
                  THR_W'($urandom_range(100000, 5000000)));
        add_frame(30, 15);
        add_frames(15);
        wait_drained();

        if (mismatch_cnt == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("tb NOT OK");
        $finish;
    end

endmodule
